// ----- hdl/csp_pkg.sv -----
// Shared types, constants and helpers for the cubic spline evaluator.
// No dependencies; imported by every module of the block but csp_ram.
`timescale 1ns / 1ps
`default_nettype none
package csp_pkg;

	localparam int MAX_KNOTS_DEF = 256;
	localparam int DATA_W        = 32;
	localparam int SEG_W         = 8;
	localparam int CNT_REG_W     = 9;
	localparam int S_TDATA_W     = 200;
	localparam int M_TDATA_W     = 40;
	localparam int CFG_IDX_W     = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTRAP_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_SLOPE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SLOPE = 2'd3;

	// req_type codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	// one knot table row, pos in the low bits
	typedef struct packed {
		logic signed [DATA_W-1:0] cub;
		logic signed [DATA_W-1:0] quad;
		logic signed [DATA_W-1:0] lin;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] pos;
	} knot_row_t;

	localparam int ROW_W = $bits(knot_row_t);

	typedef struct packed {
		logic [CNT_REG_W-1:0]     knot_count;
		logic                     extrap_mode;
		logic signed [DATA_W-1:0] left_slope;
		logic signed [DATA_W-1:0] right_slope;
	} csp_cfg_t;

	typedef enum logic [1:0] {
		MAC_NONE,
		MAC_SUB,
		MAC_MUL,
		MAC_ADD
	} mac_op_t;

	// command to the shared multiply-add unit
	typedef struct packed {
		mac_op_t                  op;
		logic                     clr;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} mac_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [SEG_W-1:0]         seg;
		logic                     ovf;
	} csp_result_t;

	// saturate to signed 32 bits; returns {saturated, value}
	function automatic logic [DATA_W:0] sat32(input logic signed [48:0] v);
		logic [DATA_W:0] r;
		if (v > 49'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -49'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[DATA_W-1:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/csp_ram.sv -----
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module csp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/csp_mac.sv -----
// Shared arithmetic unit: saturating subtract, registered 32x32 multiply,
// and Q16.16 accumulate with saturation. Sticky overflow flag.
// Depends on csp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csp_mac
	import csp_pkg::*;
(
	input  wire                      clk,
	input  wire                      arst_n,
	input  mac_cmd_t                 cmd,
	output logic signed [DATA_W-1:0] res,
	output logic                     ovf
);

	logic signed [63:0]       prod_q;
	logic signed [DATA_W-1:0] res_q;
	logic                     ovf_q;
	logic signed [48:0]       sum;
	logic [DATA_W:0]          sat_r;

	always_comb begin
		// product is floored by the arithmetic shift
		if (cmd.op == MAC_SUB) begin
			sum = 49'(cmd.a) - 49'(cmd.b);
		end else begin
			sum = 49'(cmd.a) + 49'(prod_q >>> 16);
		end
		sat_r = sat32(sum);
	end

	always_ff @(posedge clk) begin
		if (cmd.op == MAC_MUL) begin
			prod_q <= 64'(cmd.a) * 64'(cmd.b);
		end
		if (cmd.op == MAC_SUB || cmd.op == MAC_ADD) begin
			res_q <= sat_r[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd.clr) begin
			ovf_q <= 1'b0;
		end else if (cmd.op == MAC_SUB || cmd.op == MAC_ADD) begin
			ovf_q <= ovf_q | sat_r[DATA_W];
		end
	end

	assign res = res_q;
	assign ovf = ovf_q;

endmodule
`default_nettype wire

// ----- hdl/csp_seq.sv -----
// Evaluation sequencer: last-segment check, binary search over the knot RAM,
// end checks and Horner steps issued to the shared multiply-add unit.
// Depends on csp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csp_seq
	import csp_pkg::*;
#(
	parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire signed [DATA_W-1:0]         point,
	input  csp_cfg_t                        cfg,
	input  wire                             out_free,
	output logic                            idle,
	output logic                            res_valid,
	output csp_result_t                     result,
	output logic [$clog2(MAX_KNOTS)-1:0]    raddr,
	input  wire [ROW_W-1:0]                 rdata,
	output mac_cmd_t                        cmd,
	input  wire signed [DATA_W-1:0]         mac_res,
	input  wire                             mac_ovf
);

	localparam int IDX_W = $clog2(MAX_KNOTS);
	localparam int CNT_W = $clog2(MAX_KNOTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK0,
		ST_CHK1,
		ST_PROBE,
		ST_END0,
		ST_END1,
		ST_ROW,
		ST_DXC,
		ST_ADD,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t                   state_q, state_d;
	logic [IDX_W-1:0]         raddr_q;
	logic [CNT_W-1:0]         lo_q, hi_q, k_q;
	logic [IDX_W-1:0]         i_q;
	logic [SEG_W-1:0]         last_seg_q;
	logic signed [DATA_W-1:0] u_q;
	logic signed [DATA_W-1:0] dx_q;
	logic                     left_q, right_q;
	logic [1:0]               stage_q;

	knot_row_t                rrow;
	logic [31:0]              n_wide;
	logic [CNT_W-1:0]         n_c;
	logic                     hit_ok, nxt_ok;
	logic                     u_lt_pos, pos_lt_u;
	logic                     search_on, more, found;
	logic [CNT_W-1:0]         sel_lo, sel_hi, kmid;
	logic [CNT_W:0]           lohi;
	logic [IDX_W-1:0]         last_idx, found_i;

	assign rrow     = knot_row_t'(rdata);
	assign u_lt_pos = u_q < rrow.pos;
	assign pos_lt_u = rrow.pos < u_q;
	assign last_idx = IDX_W'(last_seg_q);

	// knot count in use: 0 acts as 1, clipped to the table depth
	always_comb begin
		if (cfg.knot_count == '0) begin
			n_wide = 32'd1;
		end else if (32'(cfg.knot_count) > 32'(MAX_KNOTS)) begin
			n_wide = 32'(MAX_KNOTS);
		end else begin
			n_wide = 32'(cfg.knot_count);
		end
	end
	assign n_c    = CNT_W'(n_wide);
	assign hit_ok = 32'(last_seg_q) < n_wide;
	assign nxt_ok = (32'(last_seg_q) + 32'd1) < n_wide;

	always_comb begin
		search_on = (state_q == ST_IDLE && start && !hit_ok) ||
			(state_q == ST_CHK0 && u_lt_pos) ||
			(state_q == ST_CHK1 && pos_lt_u) ||
			(state_q == ST_PROBE);
		if (state_q == ST_PROBE) begin
			sel_lo = u_lt_pos ? lo_q : k_q;
			sel_hi = u_lt_pos ? k_q : hi_q;
		end else begin
			sel_lo = '0;
			sel_hi = n_c;
		end
		lohi  = (CNT_W+1)'(sel_lo) + (CNT_W+1)'(sel_hi);
		kmid  = lohi[CNT_W:1];
		more  = (CNT_W+1)'(sel_hi) > ((CNT_W+1)'(sel_lo) + (CNT_W+1)'(1));
		found = (search_on && !more) ||
			(state_q == ST_CHK0 && !u_lt_pos && !nxt_ok) ||
			(state_q == ST_CHK1 && !pos_lt_u);
		found_i = search_on ? IDX_W'(sel_lo) : last_idx;
	end

	always_comb begin
		state_d = state_q;
		raddr   = raddr_q;
		cmd     = '0;
		cmd.op  = MAC_NONE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.clr = start;
				if (start && hit_ok) begin
					raddr   = last_idx;
					state_d = ST_CHK0;
				end
			end
			ST_CHK0: begin
				if (!u_lt_pos && nxt_ok) begin
					raddr   = IDX_W'(32'(last_seg_q) + 32'd1);
					state_d = ST_CHK1;
				end
			end
			ST_CHK1, ST_PROBE: begin
			end
			ST_END0: begin
				raddr   = IDX_W'(n_wide - 32'd1);
				state_d = ST_END1;
			end
			ST_END1: begin
				raddr   = i_q;
				state_d = ST_ROW;
			end
			ST_ROW: begin
				cmd.op  = MAC_SUB;
				cmd.a   = u_q;
				cmd.b   = rrow.pos;
				state_d = ST_DXC;
			end
			ST_DXC: begin
				cmd.op = MAC_MUL;
				cmd.a  = mac_res;
				if (left_q) begin
					cmd.b = cfg.left_slope;
				end else if (right_q) begin
					cmd.b = cfg.right_slope;
				end else begin
					cmd.b = rrow.cub;
				end
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.op = MAC_ADD;
				unique case (stage_q)
					2'd0:    cmd.a = rrow.quad;
					2'd1:    cmd.a = rrow.lin;
					default: cmd.a = rrow.value;
				endcase
				state_d = (stage_q == 2'd2) ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				cmd.op  = MAC_MUL;
				cmd.a   = dx_q;
				cmd.b   = mac_res;
				state_d = ST_ADD;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (search_on && more) begin
			raddr   = IDX_W'(kmid);
			state_d = ST_PROBE;
		end else if (found) begin
			raddr   = cfg.extrap_mode ? '0 : found_i;
			state_d = cfg.extrap_mode ? ST_END0 : ST_ROW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			raddr_q    <= '0;
			last_seg_q <= '0;
			left_q     <= 1'b0;
			right_q    <= 1'b0;
			stage_q    <= 2'd0;
			lo_q       <= '0;
			hi_q       <= '0;
			k_q        <= '0;
			i_q        <= '0;
		end else begin
			state_q <= state_d;
			raddr_q <= raddr;
			if (state_q == ST_IDLE && start) begin
				left_q  <= 1'b0;
				right_q <= 1'b0;
			end
			if (search_on) begin
				lo_q <= sel_lo;
				hi_q <= sel_hi;
				k_q  <= kmid;
			end
			if (found) begin
				i_q <= found_i;
			end
			if (state_q == ST_END0) begin
				left_q <= u_lt_pos;
			end
			if (state_q == ST_END1) begin
				right_q <= pos_lt_u;
			end
			if (state_q == ST_DXC) begin
				stage_q <= (left_q || right_q) ? 2'd2 : 2'd0;
			end else if (state_q == ST_ADD) begin
				stage_q <= stage_q + 2'd1;
			end
			if (state_q == ST_FIN && out_free) begin
				last_seg_q <= SEG_W'(i_q);
			end
		end
	end

	// payload holding registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			u_q <= point;
		end
		if (state_q == ST_DXC) begin
			dx_q <= mac_res;
		end
	end

	assign idle         = (state_q == ST_IDLE);
	assign res_valid    = (state_q == ST_FIN);
	assign result.value = mac_res;
	assign result.seg   = SEG_W'(i_q);
	assign result.ovf   = mac_ovf;

endmodule
`default_nettype wire

// ----- hdl/cubic_spline_evaluator.sv -----
// Piecewise cubic spline evaluator, Q16.16, one shared multiply-add unit (csp_pkg,
// csp_ram, csp_mac, csp_seq). Load words are written to the knot RAM without stalling
// the input. An evaluate word runs up to 2 last-segment checks, a binary search of up
// to 8 probes at 256 knots, end checks in extrap mode and the Horner steps; a linear
// end multiplies by the end slope and adds the knot value. Input is held off until the
// result word is registered, through any output stall. Reset clears control and config.
`timescale 1ns / 1ps
`default_nettype none
module cubic_spline_evaluator
	import csp_pkg::*;
#(
	parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// entry_index[7:0], knot_pos, knot_value, coef_lin, coef_quad, coef_cub,
	// eval_point (32 bits each, upward from bit 8)
	input  wire [S_TDATA_W-1:0]  s_tdata,
	input  wire                  s_tuser,   // req_type
	input  wire                  s_tlast,   // batch_end
	input  wire                  s_tvalid,
	output logic                 s_tready,
	// spline_value[31:0], segment_used[39:32]
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser,   // overflowed
	output logic                 m_tlast,   // last_of_batch
	output logic                 m_tvalid,
	input  wire                  m_tready,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(MAX_KNOTS);

	csp_cfg_t            cfg_q;
	logic                m_tvalid_q, m_tuser_q, m_tlast_q, batch_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                accept, start, load_we;
	logic                idle, res_valid, out_free;
	csp_result_t         result;
	logic [IDX_W-1:0]    raddr;
	logic [ROW_W-1:0]    rdata;
	knot_row_t           wrow;
	mac_cmd_t            cmd;
	logic signed [DATA_W-1:0] mac_res;
	logic                mac_ovf;

	assign accept   = s_tvalid && s_tready;
	assign start    = accept && (s_tuser == REQ_EVAL);
	assign load_we  = accept && (s_tuser == REQ_LOAD) && (32'(s_tdata[7:0]) < 32'(MAX_KNOTS));
	assign out_free = !m_tvalid_q || m_tready;

	assign wrow.pos   = s_tdata[39:8];
	assign wrow.value = s_tdata[71:40];
	assign wrow.lin   = s_tdata[103:72];
	assign wrow.quad  = s_tdata[135:104];
	assign wrow.cub   = s_tdata[167:136];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.knot_count  <= CNT_REG_W'(1);
			cfg_q.extrap_mode <= 1'b0;
			cfg_q.left_slope  <= '0;
			cfg_q.right_slope <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KNOT_COUNT:  cfg_q.knot_count  <= cfg_data[CNT_REG_W-1:0];
				REG_EXTRAP_MODE: cfg_q.extrap_mode <= cfg_data[0];
				REG_LEFT_SLOPE:  cfg_q.left_slope  <= cfg_data;
				REG_RIGHT_SLOPE: cfg_q.right_slope <= cfg_data;
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			batch_q <= s_tlast;
		end
		if (res_valid && out_free) begin
			m_tdata_q <= {result.seg, result.value};
			m_tuser_q <= result.ovf;
			m_tlast_q <= batch_q;
		end
	end

	csp_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_KNOTS)
	) u_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (IDX_W'(s_tdata[7:0])),
		.wdata (wrow),
		.raddr (raddr),
		.rdata (rdata)
	);

	csp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (mac_res),
		.ovf    (mac_ovf)
	);

	csp_seq #(
		.MAX_KNOTS(MAX_KNOTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.point     (s_tdata[199:168]),
		.cfg       (cfg_q),
		.out_free  (out_free),
		.idle      (idle),
		.res_valid (res_valid),
		.result    (result),
		.raddr     (raddr),
		.rdata     (rdata),
		.cmd       (cmd),
		.mac_res   (mac_res),
		.mac_ovf   (mac_ovf)
	);

	assign s_tready = idle;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

// ----- hdl/csp_checker.sv -----
// Port-level assertions for the spline evaluator, bound to the top level.
// Depends on csp_pkg and cubic_spline_evaluator.
`timescale 1ns / 1ps
`default_nettype none
module csp_checker
	import csp_pkg::*;
(
	input wire                 clk,
	input wire                 arst_n,
	input wire                 s_tvalid,
	input wire                 s_tready,
	input wire                 s_tuser,
	input wire                 m_tvalid,
	input wire                 m_tready,
	input wire [M_TDATA_W-1:0] m_tdata
);

	// an evaluate word makes the block busy
	ast_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_EVAL |=> !s_tready)
		else $error("ready stayed high after an evaluate word");

	// a load word never stalls the input
	ast_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_LOAD |=> s_tready)
		else $error("ready dropped after a load word");

	// a result appears only at the end of an evaluation
	ast_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result word without a pending evaluation");

	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

endmodule

bind cubic_spline_evaluator csp_checker u_csp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
